@@ rtl/fft8_pkg.sv @@
// ----------------------------------------------------------------------------
// fft8_pkg
// Shared constants and elaboration-time helpers for the 8-point forward FFT.
// ----------------------------------------------------------------------------
`default_nettype none

package fft8_pkg;

    localparam int NUM_POINTS            = 8;
    localparam int SAMPLE_BITS_DEF       = 16;
    localparam int TWIDDLE_FRAC_BITS_DEF = 15;
    // output part is SAMPLE_BITS + GROWTH_BITS + 1 bits wide
    localparam int GROWTH_BITS           = 3;

    // round(2^frac / sqrt(2)) = round(sqrt(2^(2*frac-1))), elaboration only
    function automatic longint rt2_coef(input int frac);
        longint v;
        longint r;
        longint t;
        v = longint'(1) << (2 * frac - 1);
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            t = r | (longint'(1) << k);
            if (t * t <= v) begin
                r = t;
            end
        end
        if (v - r * r > r) begin
            r = r + 1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fft8_radix2.sv @@
// ----------------------------------------------------------------------------
// fft8_radix2
// Unpacks the eight samples and runs the first radix-2 butterfly stage,
// with the -j twiddle on the third pair folded in as swap and negate.
// ----------------------------------------------------------------------------
`default_nettype none

module fft8_radix2 #(
    parameter int SAMPLE_BITS = fft8_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2*SAMPLE_BITS-1:0]      sample [fft8_pkg::NUM_POINTS],
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS:0]        a_re [fft8_pkg::NUM_POINTS],
    output logic signed [SAMPLE_BITS:0]        a_im [fft8_pkg::NUM_POINTS]
);

    localparam int AW = SAMPLE_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] x_re [fft8_pkg::NUM_POINTS];
    logic signed [SAMPLE_BITS-1:0] x_im [fft8_pkg::NUM_POINTS];
    logic signed [AW-1:0] a_re_next [fft8_pkg::NUM_POINTS];
    logic signed [AW-1:0] a_im_next [fft8_pkg::NUM_POINTS];
    logic signed [AW-1:0] a_re_reg  [fft8_pkg::NUM_POINTS];
    logic signed [AW-1:0] a_im_reg  [fft8_pkg::NUM_POINTS];
    logic                 valid_reg;

    always_comb begin
        for (int i = 0; i < fft8_pkg::NUM_POINTS; i++) begin
            x_re[i] = $signed(sample[i][2*SAMPLE_BITS-1:SAMPLE_BITS]);
            x_im[i] = $signed(sample[i][SAMPLE_BITS-1:0]);
        end
        a_re_next[0] = AW'(x_re[0]) + AW'(x_re[4]);
        a_im_next[0] = AW'(x_im[0]) + AW'(x_im[4]);
        a_re_next[1] = AW'(x_re[0]) - AW'(x_re[4]);
        a_im_next[1] = AW'(x_im[0]) - AW'(x_im[4]);
        a_re_next[2] = AW'(x_re[1]) + AW'(x_re[5]);
        a_im_next[2] = AW'(x_im[1]) + AW'(x_im[5]);
        a_re_next[3] = AW'(x_re[1]) - AW'(x_re[5]);
        a_im_next[3] = AW'(x_im[1]) - AW'(x_im[5]);
        a_re_next[4] = AW'(x_re[2]) + AW'(x_re[6]);
        a_im_next[4] = AW'(x_im[2]) + AW'(x_im[6]);
        // -j: swap and negate
        a_re_next[5] = AW'(x_im[2]) - AW'(x_im[6]);
        a_im_next[5] = AW'(x_re[6]) - AW'(x_re[2]);
        a_re_next[6] = AW'(x_re[3]) + AW'(x_re[7]);
        a_im_next[6] = AW'(x_im[3]) + AW'(x_im[7]);
        // negated difference
        a_re_next[7] = AW'(x_re[7]) - AW'(x_re[3]);
        a_im_next[7] = AW'(x_im[7]) - AW'(x_im[3]);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            a_re_reg <= a_re_next;
            a_im_reg <= a_im_next;
        end
    end

    assign out_valid = valid_reg;
    assign a_re      = a_re_reg;
    assign a_im      = a_im_reg;

endmodule

`default_nettype wire

@@ rtl/fft8_rotate.sv @@
// ----------------------------------------------------------------------------
// fft8_rotate
// W1 and W3 twiddles on points 3 and 7: pre-add, multiply by 1/sqrt(2)
// in fixed point, round. Three register stages; other points ride along.
// ----------------------------------------------------------------------------
`default_nettype none

module fft8_rotate #(
    parameter int SAMPLE_BITS       = fft8_pkg::SAMPLE_BITS_DEF,
    parameter int TWIDDLE_FRAC_BITS = fft8_pkg::TWIDDLE_FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS:0]   a_re [fft8_pkg::NUM_POINTS],
    input  wire logic signed [SAMPLE_BITS:0]   a_im [fft8_pkg::NUM_POINTS],
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS+1:0]      c_re [fft8_pkg::NUM_POINTS],
    output logic signed [SAMPLE_BITS+1:0]      c_im [fft8_pkg::NUM_POINTS]
);

    localparam int NP = fft8_pkg::NUM_POINTS;
    localparam int AW = SAMPLE_BITS + 1;
    localparam int SW = SAMPLE_BITS + 2;
    localparam int PW = SW + TWIDDLE_FRAC_BITS + 1;
    localparam logic signed [TWIDDLE_FRAC_BITS:0] COEF =
        (TWIDDLE_FRAC_BITS+1)'(fft8_pkg::rt2_coef(TWIDDLE_FRAC_BITS));
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (TWIDDLE_FRAC_BITS - 1);
    // rotation lanes: 0 = p3 re, 1 = p3 im, 2 = p7 re, 3 = p7 im
    localparam int NR = 4;

    logic [2:0] valid_reg;
    logic [2:0] adv;

    logic signed [AW-1:0] s1_re_reg [NP];
    logic signed [AW-1:0] s1_im_reg [NP];
    logic signed [SW-1:0] sum_next  [NR];
    logic signed [SW-1:0] sum_reg   [NR];

    logic signed [AW-1:0] s2_re_reg [NP];
    logic signed [AW-1:0] s2_im_reg [NP];
    logic signed [PW-1:0] prod_next [NR];
    logic signed [PW-1:0] prod_reg  [NR];

    logic signed [PW-1:0] rnd_full  [NR];
    logic signed [SW-1:0] c_re_next [NP];
    logic signed [SW-1:0] c_im_next [NP];
    logic signed [SW-1:0] c_re_reg  [NP];
    logic signed [SW-1:0] c_im_reg  [NP];

    assign adv[2]   = !valid_reg[2] || out_ready;
    assign adv[1]   = !valid_reg[1] || adv[2];
    assign adv[0]   = !valid_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_comb begin
        sum_next[0] = SW'(a_re[3]) + SW'(a_im[3]);
        sum_next[1] = SW'(a_im[3]) - SW'(a_re[3]);
        sum_next[2] = SW'(a_re[7]) - SW'(a_im[7]);
        sum_next[3] = SW'(a_im[7]) + SW'(a_re[7]);
        for (int k = 0; k < NR; k++) begin
            prod_next[k] = PW'(sum_reg[k]) * PW'(COEF);
            rnd_full[k]  = (prod_reg[k] + HALF) >>> TWIDDLE_FRAC_BITS;
        end
        for (int i = 0; i < NP; i++) begin
            c_re_next[i] = SW'(s2_re_reg[i]);
            c_im_next[i] = SW'(s2_im_reg[i]);
        end
        c_re_next[3] = rnd_full[0][SW-1:0];
        c_im_next[3] = rnd_full[1][SW-1:0];
        c_re_next[7] = rnd_full[2][SW-1:0];
        c_im_next[7] = rnd_full[3][SW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= in_valid;
            end
            if (adv[1]) begin
                valid_reg[1] <= valid_reg[0];
            end
            if (adv[2]) begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0] && in_valid) begin
            s1_re_reg <= a_re;
            s1_im_reg <= a_im;
            sum_reg   <= sum_next;
        end
        if (adv[1] && valid_reg[0]) begin
            s2_re_reg <= s1_re_reg;
            s2_im_reg <= s1_im_reg;
            prod_reg  <= prod_next;
        end
        if (adv[2] && valid_reg[1]) begin
            c_re_reg <= c_re_next;
            c_im_reg <= c_im_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign c_re      = c_re_reg;
    assign c_im      = c_im_reg;

endmodule

`default_nettype wire

@@ rtl/fft8_dft4.sv @@
// ----------------------------------------------------------------------------
// fft8_dft4
// Two 4-point butterfly stages on the even and odd halves, one register
// stage each, giving the bins in natural order.
// ----------------------------------------------------------------------------
`default_nettype none

module fft8_dft4 #(
    parameter int SAMPLE_BITS = fft8_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS+1:0] c_re [fft8_pkg::NUM_POINTS],
    input  wire logic signed [SAMPLE_BITS+1:0] c_im [fft8_pkg::NUM_POINTS],
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS+fft8_pkg::GROWTH_BITS:0] y_re [fft8_pkg::NUM_POINTS],
    output logic signed [SAMPLE_BITS+fft8_pkg::GROWTH_BITS:0] y_im [fft8_pkg::NUM_POINTS]
);

    localparam int NP = fft8_pkg::NUM_POINTS;
    localparam int BW = SAMPLE_BITS + 3;
    localparam int YW = SAMPLE_BITS + fft8_pkg::GROWTH_BITS + 1;

    logic [1:0] valid_reg;
    logic [1:0] adv;

    logic signed [BW-1:0] b_re_next [NP];
    logic signed [BW-1:0] b_im_next [NP];
    logic signed [BW-1:0] b_re_reg  [NP];
    logic signed [BW-1:0] b_im_reg  [NP];
    logic signed [YW-1:0] y_re_next [NP];
    logic signed [YW-1:0] y_im_next [NP];
    logic signed [YW-1:0] y_re_reg  [NP];
    logic signed [YW-1:0] y_im_reg  [NP];

    assign adv[1]   = !valid_reg[1] || out_ready;
    assign adv[0]   = !valid_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_comb begin
        b_re_next[0] = BW'(c_re[0]) + BW'(c_re[4]);
        b_im_next[0] = BW'(c_im[0]) + BW'(c_im[4]);
        b_re_next[1] = BW'(c_re[0]) - BW'(c_re[4]);
        b_im_next[1] = BW'(c_im[0]) - BW'(c_im[4]);
        b_re_next[2] = BW'(c_re[2]) + BW'(c_re[6]);
        b_im_next[2] = BW'(c_im[2]) + BW'(c_im[6]);
        b_re_next[3] = BW'(c_re[2]) - BW'(c_re[6]);
        b_im_next[3] = BW'(c_im[2]) - BW'(c_im[6]);
        b_re_next[4] = BW'(c_re[1]) + BW'(c_re[5]);
        b_im_next[4] = BW'(c_im[1]) + BW'(c_im[5]);
        b_re_next[5] = BW'(c_re[1]) - BW'(c_re[5]);
        b_im_next[5] = BW'(c_im[1]) - BW'(c_im[5]);
        b_re_next[6] = BW'(c_re[3]) + BW'(c_re[7]);
        b_im_next[6] = BW'(c_im[3]) + BW'(c_im[7]);
        b_re_next[7] = BW'(c_re[3]) - BW'(c_re[7]);
        b_im_next[7] = BW'(c_im[3]) - BW'(c_im[7]);

        y_re_next[0] = YW'(b_re_reg[0]) + YW'(b_re_reg[2]);
        y_im_next[0] = YW'(b_im_reg[0]) + YW'(b_im_reg[2]);
        y_re_next[2] = YW'(b_re_reg[1]) + YW'(b_im_reg[3]);
        y_im_next[2] = YW'(b_im_reg[1]) - YW'(b_re_reg[3]);
        y_re_next[4] = YW'(b_re_reg[0]) - YW'(b_re_reg[2]);
        y_im_next[4] = YW'(b_im_reg[0]) - YW'(b_im_reg[2]);
        y_re_next[6] = YW'(b_re_reg[1]) - YW'(b_im_reg[3]);
        y_im_next[6] = YW'(b_im_reg[1]) + YW'(b_re_reg[3]);
        y_re_next[1] = YW'(b_re_reg[4]) + YW'(b_re_reg[6]);
        y_im_next[1] = YW'(b_im_reg[4]) + YW'(b_im_reg[6]);
        y_re_next[3] = YW'(b_re_reg[5]) + YW'(b_im_reg[7]);
        y_im_next[3] = YW'(b_im_reg[5]) - YW'(b_re_reg[7]);
        y_re_next[5] = YW'(b_re_reg[4]) - YW'(b_re_reg[6]);
        y_im_next[5] = YW'(b_im_reg[4]) - YW'(b_im_reg[6]);
        y_re_next[7] = YW'(b_re_reg[5]) - YW'(b_im_reg[7]);
        y_im_next[7] = YW'(b_im_reg[5]) + YW'(b_re_reg[7]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= in_valid;
            end
            if (adv[1]) begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0] && in_valid) begin
            b_re_reg <= b_re_next;
            b_im_reg <= b_im_next;
        end
        if (adv[1] && valid_reg[0]) begin
            y_re_reg <= y_re_next;
            y_im_reg <= y_im_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign y_re      = y_re_reg;
    assign y_im      = y_im_reg;

endmodule

`default_nettype wire

@@ rtl/fft8_forward_top.sv @@
// ----------------------------------------------------------------------------
// fft8_forward_top
// Streaming forward 8-point FFT, fully pipelined, 1 block/clock unless stalled.
// ----------------------------------------------------------------------------
// Each request on the s_ side carries one block of eight complex samples
// (real part in the upper half of each word, imaginary in the lower, both
// two's complement). Each request on the m_ side returns the eight DFT bins
// X[k] = sum x[n] exp(-j 2 pi n k / 8) in natural order, packed the same way
// with SAMPLE_BITS+4 bits per part: full growth, no scaling, no saturation.
// The W1/W3 twiddles use the Q1.TWIDDLE_FRAC_BITS constant round(2^F/sqrt 2)
// with round-half-up after the product; every other add is exact.
// Throughput is one block per cycle while m_ready is high; m_valid rises
// once a block has passed the six register stages (the first one loads on
// the accepting edge itself): first butterfly, twiddle pre-add, twiddle
// multiply, round, and two 4-point butterfly stages. The last stage
// is the output register; backpressure on m_ready ripples back through the
// per-stage valid bits, so bubbles are squeezed out and nothing is dropped.
// There is no state between blocks; reset only clears the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fft8_forward_top #(
    parameter int SAMPLE_BITS       = fft8_pkg::SAMPLE_BITS_DEF,
    parameter int TWIDDLE_FRAC_BITS = fft8_pkg::TWIDDLE_FRAC_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [2*SAMPLE_BITS-1:0]              s_sample_0,
    input  wire logic [2*SAMPLE_BITS-1:0]              s_sample_1,
    input  wire logic [2*SAMPLE_BITS-1:0]              s_sample_2,
    input  wire logic [2*SAMPLE_BITS-1:0]              s_sample_3,
    input  wire logic [2*SAMPLE_BITS-1:0]              s_sample_4,
    input  wire logic [2*SAMPLE_BITS-1:0]              s_sample_5,
    input  wire logic [2*SAMPLE_BITS-1:0]              s_sample_6,
    input  wire logic [2*SAMPLE_BITS-1:0]              s_sample_7,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [2*(SAMPLE_BITS+fft8_pkg::GROWTH_BITS+1)-1:0] m_bin_0,
    output logic [2*(SAMPLE_BITS+fft8_pkg::GROWTH_BITS+1)-1:0] m_bin_1,
    output logic [2*(SAMPLE_BITS+fft8_pkg::GROWTH_BITS+1)-1:0] m_bin_2,
    output logic [2*(SAMPLE_BITS+fft8_pkg::GROWTH_BITS+1)-1:0] m_bin_3,
    output logic [2*(SAMPLE_BITS+fft8_pkg::GROWTH_BITS+1)-1:0] m_bin_4,
    output logic [2*(SAMPLE_BITS+fft8_pkg::GROWTH_BITS+1)-1:0] m_bin_5,
    output logic [2*(SAMPLE_BITS+fft8_pkg::GROWTH_BITS+1)-1:0] m_bin_6,
    output logic [2*(SAMPLE_BITS+fft8_pkg::GROWTH_BITS+1)-1:0] m_bin_7
);

    localparam int NP = fft8_pkg::NUM_POINTS;
    localparam int AW = SAMPLE_BITS + 1;                       // after first butterfly
    localparam int SW = SAMPLE_BITS + 2;                       // after twiddles
    localparam int YW = SAMPLE_BITS + fft8_pkg::GROWTH_BITS + 1; // output part

    logic [2*SAMPLE_BITS-1:0] sample [NP];

    logic                 r2_valid;
    logic                 r2_ready;
    logic signed [AW-1:0] a_re [NP];
    logic signed [AW-1:0] a_im [NP];

    logic                 rot_valid;
    logic                 rot_ready;
    logic signed [SW-1:0] c_re [NP];
    logic signed [SW-1:0] c_im [NP];

    logic signed [YW-1:0] y_re [NP];
    logic signed [YW-1:0] y_im [NP];
    logic [2*YW-1:0]      bin  [NP];

    assign sample[0] = s_sample_0;
    assign sample[1] = s_sample_1;
    assign sample[2] = s_sample_2;
    assign sample[3] = s_sample_3;
    assign sample[4] = s_sample_4;
    assign sample[5] = s_sample_5;
    assign sample[6] = s_sample_6;
    assign sample[7] = s_sample_7;

    // stage 1: radix-2 butterflies, -j folded in
    fft8_radix2 #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_radix2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .sample    (sample),
        .out_valid (r2_valid),
        .out_ready (r2_ready),
        .a_re      (a_re),
        .a_im      (a_im)
    );

    // stages 2-4: W1/W3 rotation of points 3 and 7
    fft8_rotate #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .TWIDDLE_FRAC_BITS (TWIDDLE_FRAC_BITS)
    ) u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (r2_valid),
        .in_ready  (r2_ready),
        .a_re      (a_re),
        .a_im      (a_im),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .c_re      (c_re),
        .c_im      (c_im)
    );

    // stages 5-6: 4-point butterflies; last stage is the output register
    fft8_dft4 #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dft4 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .c_re      (c_re),
        .c_im      (c_im),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .y_re      (y_re),
        .y_im      (y_im)
    );

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            bin[i] = {y_re[i], y_im[i]};
        end
    end

    assign m_bin_0 = bin[0];
    assign m_bin_1 = bin[1];
    assign m_bin_2 = bin[2];
    assign m_bin_3 = bin[3];
    assign m_bin_4 = bin[4];
    assign m_bin_5 = bin[5];
    assign m_bin_6 = bin[6];
    assign m_bin_7 = bin[7];

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 8-point forward FFT.
// ----------------------------------------------------------------------------
// Blocks of eight complex samples are fed through a valid/ready request
// channel. Each accepted request is run through a bit-exact fixed-point DFT
// predictor, and the bins it yields are queued. Every result request is then
// checked bin by bin against the oldest entry in that queue. A short
// directed set comes first: full-scale and most-negative parts, alternating
// signs, impulses at every position, and the twiddle rounding ties of both
// signs. Random blocks follow. The sender idles in bursts and the receiver
// stalls on its own pattern. One long receiver hold-off fills the pipeline
// and backs up the input, and at times the sender waits for a full drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int SW      = fft8_pkg::SAMPLE_BITS_DEF;
    localparam int TF      = fft8_pkg::TWIDDLE_FRAC_BITS_DEF;
    localparam int PW      = SW + fft8_pkg::GROWTH_BITS + 1;
    localparam int NPT     = fft8_pkg::NUM_POINTS;
    // round(2^15 / sqrt(2)), the Q1.15 value of 1/sqrt(2)
    localparam longint RT2_Q = 64'sd23170;
    localparam int N_RANDOM  = 630;
    localparam int DRAIN     = 20;

    typedef logic [2*SW-1:0]          word_t;
    typedef logic [NPT-1:0][2*SW-1:0] block_t;
    typedef logic [NPT-1:0][2*PW-1:0] bins_t;

    // one pending request; hold_drain makes the sender wait for an empty pipe
    typedef struct packed {
        logic   hold_drain;
        block_t samples;
    } pending_t;

    logic  aclk    = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    word_t s_sample [NPT];
    logic  m_valid;
    logic  m_ready = 1'b0;
    logic [2*PW-1:0] m_bin [NPT];

    pending_t pending_blocks [$];
    bins_t    expected_bins [$];

    int     total_blocks    = 0;
    int     blocks_accepted = 0;
    int     results_seen    = 0;
    int     errors          = 0;
    bit     req_taken       = 1'b0;
    int     burst_left      = 0;
    int     gap_left        = 0;
    int     rx_cycle        = 0;
    int     holdoff_left    = 0;
    bit     holdoff_done    = 1'b0;
    logic   rx_next;
    block_t s_block;
    bins_t  m_block;
    bins_t  want;

    initial begin
        for (int i = 0; i < NPT; i++) begin
            s_sample[i] = '0;
        end
    end

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    fft8_forward_top u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample_0 (s_sample[0]),
        .s_sample_1 (s_sample[1]),
        .s_sample_2 (s_sample[2]),
        .s_sample_3 (s_sample[3]),
        .s_sample_4 (s_sample[4]),
        .s_sample_5 (s_sample[5]),
        .s_sample_6 (s_sample[6]),
        .s_sample_7 (s_sample[7]),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_bin_0    (m_bin[0]),
        .m_bin_1    (m_bin[1]),
        .m_bin_2    (m_bin[2]),
        .m_bin_3    (m_bin[3]),
        .m_bin_4    (m_bin[4]),
        .m_bin_5    (m_bin[5]),
        .m_bin_6    (m_bin[6]),
        .m_bin_7    (m_bin[7])
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // v / sqrt(2) in fixed point: product, add half, arithmetic shift,
    // so ties go toward plus infinity
    function automatic longint times_rt2(input longint v);
        return (v * RT2_Q + (longint'(1) << (TF - 1))) >>> TF;
    endfunction

    // DIF radix-2 DFT over one block, exact adds, bins in natural order
    function automatic bins_t dft8_bins(input block_t blk);
        longint xr [NPT];
        longint xi [NPT];
        longint ar [NPT];
        longint ai [NPT];
        longint br [NPT];
        longint bi [NPT];
        longint yr [NPT];
        longint yi [NPT];
        longint t;
        bins_t  res;
        for (int n = 0; n < NPT; n++) begin
            xr[n] = longint'($signed(blk[n][2*SW-1:SW]));
            xi[n] = longint'($signed(blk[n][SW-1:0]));
        end
        // first butterflies; -j on (2,6) is a swap with negate
        ar[0] = xr[0] + xr[4];  ai[0] = xi[0] + xi[4];
        ar[1] = xr[0] - xr[4];  ai[1] = xi[0] - xi[4];
        ar[2] = xr[1] + xr[5];  ai[2] = xi[1] + xi[5];
        ar[3] = xr[1] - xr[5];  ai[3] = xi[1] - xi[5];
        ar[4] = xr[2] + xr[6];  ai[4] = xi[2] + xi[6];
        ar[5] = xi[2] - xi[6];  ai[5] = xr[6] - xr[2];
        ar[6] = xr[3] + xr[7];  ai[6] = xi[3] + xi[7];
        ar[7] = xr[7] - xr[3];  ai[7] = xi[7] - xi[3];
        // W1 and W3
        t     = times_rt2(ai[3] - ar[3]);
        ar[3] = times_rt2(ar[3] + ai[3]);
        ai[3] = t;
        t     = times_rt2(ai[7] + ar[7]);
        ar[7] = times_rt2(ar[7] - ai[7]);
        ai[7] = t;
        // two 4-point stages
        br[0] = ar[0] + ar[4];  bi[0] = ai[0] + ai[4];
        br[1] = ar[0] - ar[4];  bi[1] = ai[0] - ai[4];
        br[2] = ar[2] + ar[6];  bi[2] = ai[2] + ai[6];
        br[3] = ar[2] - ar[6];  bi[3] = ai[2] - ai[6];
        br[4] = ar[1] + ar[5];  bi[4] = ai[1] + ai[5];
        br[5] = ar[1] - ar[5];  bi[5] = ai[1] - ai[5];
        br[6] = ar[3] + ar[7];  bi[6] = ai[3] + ai[7];
        br[7] = ar[3] - ar[7];  bi[7] = ai[3] - ai[7];
        yr[0] = br[0] + br[2];  yi[0] = bi[0] + bi[2];
        yr[2] = br[1] + bi[3];  yi[2] = bi[1] - br[3];
        yr[4] = br[0] - br[2];  yi[4] = bi[0] - bi[2];
        yr[6] = br[1] - bi[3];  yi[6] = bi[1] + br[3];
        yr[1] = br[4] + br[6];  yi[1] = bi[4] + bi[6];
        yr[3] = br[5] + bi[7];  yi[3] = bi[5] - br[7];
        yr[5] = br[4] - br[6];  yi[5] = bi[4] - bi[6];
        yr[7] = br[5] - bi[7];  yi[7] = bi[5] + br[7];
        for (int k = 0; k < NPT; k++) begin
            res[k] = {yr[k][PW-1:0], yi[k][PW-1:0]};
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic word_t cpx(input int re, input int im);
        logic [31:0] r;
        logic [31:0] i;
        r = re;
        i = im;
        return {r[SW-1:0], i[SW-1:0]};
    endfunction

    // all-zero block with one sample set
    function automatic block_t impulse(input int n, input word_t w);
        block_t b;
        b    = '0;
        b[n] = w;
        return b;
    endfunction

    function automatic block_t uniform_block(input word_t w);
        block_t b;
        for (int n = 0; n < NPT; n++) begin
            b[n] = w;
        end
        return b;
    endfunction

    function automatic logic [SW-1:0] extreme_part();
        case ($urandom_range(0, 4))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            2: return '0;
            3: return '1;
            default: return SW'($urandom);
        endcase
    endfunction

    // mostly full-range words, some built from the corner values
    function automatic block_t random_block();
        block_t b;
        bit     corners;
        corners = ($urandom_range(0, 9) < 3);
        for (int n = 0; n < NPT; n++) begin
            if (corners && $urandom_range(0, 1)) begin
                b[n] = {extreme_part(), extreme_part()};
            end else begin
                b[n] = $urandom;
            end
        end
        return b;
    endfunction

    task automatic queue_block(input block_t b, input logic hold);
        pending_t p;
        p.hold_drain = hold;
        p.samples    = b;
        pending_blocks.push_back(p);
        total_blocks++;
    endtask

    // ------------------------------------------------------------------
    // Sequence, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        block_t alt;
        // directed: zero, full scale both signs, mixed signs
        queue_block('0, 1'b0);
        queue_block(uniform_block(cpx(32767, 32767)), 1'b0);
        queue_block(uniform_block(cpx(-32768, -32768)), 1'b0);
        queue_block(uniform_block(cpx(-32768, 32767)), 1'b0);
        // alternating signs drive bin 4 to its largest magnitude
        for (int n = 0; n < NPT; n++) begin
            alt[n] = (n % 2 == 0) ? cpx(32767, 32767) : cpx(-32768, -32768);
        end
        queue_block(alt, 1'b0);
        // impulse at every position exercises each butterfly path
        for (int n = 0; n < NPT; n++) begin
            queue_block(impulse(n, cpx(32767, -32768)), 1'b0);
        end
        // twiddle rounding ties: W1 positive then negative, W3 both ways
        queue_block(impulse(1, cpx(8192, 0)), 1'b0);
        queue_block(impulse(5, cpx(8192, 0)), 1'b0);
        queue_block(impulse(1, cpx(0, -8192)), 1'b0);
        queue_block(impulse(7, cpx(8192, 0)), 1'b0);
        queue_block(impulse(3, cpx(8192, 0)), 1'b0);
        queue_block(impulse(7, cpx(-24576, 0)), 1'b0);
        // small values on the -j pair
        queue_block(impulse(2, cpx(1, -1)), 1'b0);
        queue_block(impulse(6, cpx(-1, 1)), 1'b0);

        // random; two points where the sender waits for a full drain
        for (int i = 0; i < N_RANDOM; i++) begin
            queue_block(random_block(), (i == 200 || i == 450));
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (blocks_accepted < total_blocks || expected_bins.size() != 0) begin
            @(negedge aclk);
        end
        // let any stray result show up
        repeat (DRAIN) @(negedge aclk);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: bursts with random gaps, changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // request still waiting: hold valid and payload
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
        end else if (pending_blocks.size() != 0 &&
                     !(pending_blocks[0].hold_drain && expected_bins.size() != 0)) begin
            for (int n = 0; n < NPT; n++) begin
                s_sample[n] <= pending_blocks[0].samples[n];
            end
            pending_blocks[0].hold_drain = 1'b0;
            void'(pending_blocks.pop_front());
            s_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
                // sometimes no gap at all, so long back-to-back runs occur
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                burst_left = $urandom_range(1, 40);
            end
        end else begin
            s_valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // Receiver ready: phases of full rate, random stalls and a fixed
    // pattern, plus one long hold-off that backs up the whole pipe
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        rx_cycle++;
        if (!aresetn) begin
            rx_next = 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            rx_next = 1'b0;
        end else if (!holdoff_done && results_seen >= 150) begin
            holdoff_done = 1'b1;
            holdoff_left = 79;
            rx_next      = 1'b0;
        end else begin
            case ((rx_cycle / 97) % 4)
                0: rx_next = 1'b1;
                1: rx_next = 1'($urandom_range(0, 1));
                2: rx_next = ($urandom_range(0, 3) == 0);
                default: rx_next = (rx_cycle % 5 != 0);
            endcase
        end
        m_ready <= rx_next;
    end

    // ------------------------------------------------------------------
    // Monitors, sampled at the rising edge
    // ------------------------------------------------------------------

    // accepted request: predict its bins
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            for (int n = 0; n < NPT; n++) begin
                s_block[n] = s_sample[n];
            end
            expected_bins.push_back(dft8_bins(s_block));
            blocks_accepted++;
            req_taken = 1'b1;
        end
    end

    // accepted result: compare every bin with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            for (int k = 0; k < NPT; k++) begin
                m_block[k] = m_bin[k];
            end
            if (expected_bins.size() == 0) begin
                $display("%0t: unexpected result, nothing pending (bin0 %h)",
                         $time, m_block[0]);
                errors++;
            end else begin
                want = expected_bins.pop_front();
                for (int k = 0; k < NPT; k++) begin
                    if (m_block[k] !== want[k]) begin
                        $display("%0t: result %0d bin %0d expected %h actual %h",
                                 $time, results_seen, k, want[k], m_block[k]);
                        errors++;
                    end
                end
            end
            results_seen++;
        end
    end

endmodule

`default_nettype wire
